FILE: design/ptcd_pkg.sv
// Shared types and constants for the point to cell distance block.
// No dependencies; used by every module of the block.
package ptcd_pkg;

    localparam int AXES             = 3;
    localparam int PTCD_QUEUE_DEPTH = 4;
    localparam int GRID_CELLS       = 256;
    localparam int IDX_W            = 8;
    localparam int CS_W             = 31;
    localparam int LO_W             = IDX_W + CS_W;
    localparam int DIFF_W           = LO_W + 2;
    localparam int TERM_W           = 32;
    localparam int SQ_W             = 2 * TERM_W;
    localparam int SUM_W            = SQ_W + 2;
    localparam int REM_W            = TERM_W + 2;

    // Largest index within the grid
    localparam int IDX_MAX_INT = (GRID_CELLS - 1 > 255) ? 255 : GRID_CELLS - 1;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_MAX_INT[IDX_W-1:0];

    // case_taken codes
    localparam logic [1:0] CASE_FACE   = 2'd0;
    localparam logic [1:0] CASE_EDGE   = 2'd1;
    localparam logic [1:0] CASE_CORNER = 2'd2;

    // Register address
    localparam logic [1:0] ADDR_CELL_SIZE = 2'd0;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic [AXES-1:0][TERM_W-1:0] terms;
        logic [1:0]                  kase;
        logic                        sat;
    } ptcd_item_t;

    // Clamp a cell index to the grid
    function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] idx);
        clamp_idx = (idx > IDX_MAX) ? IDX_MAX : idx;
    endfunction

endpackage

FILE: design/ptcd_front.sv
// Front part: takes items, forms cell corners, classifies face/edge/corner.
// Depends on ptcd_pkg.
module ptcd_front
    import ptcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = PTCD_QUEUE_DEPTH,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CS_W-1:0]         cell_size,
    input  logic                    push,
    output logic                    full,
    input  logic signed [31:0]      point_x,
    input  logic signed [31:0]      point_y,
    input  logic signed [31:0]      point_z,
    input  logic [IDX_W-1:0]        cell_x,
    input  logic [IDX_W-1:0]        cell_y,
    input  logic [IDX_W-1:0]        cell_z,
    input  logic [CNT_W-1:0]        queue_count,
    output logic                    wr_valid,
    output ptcd_item_t              wr_item
);

    logic                          valid_a_reg;
    logic [AXES-1:0][31:0]         p_a_reg;
    logic [AXES-1:0][LO_W-1:0]     lo_a_reg;
    logic                          accept;
    logic [AXES-1:0][31:0]         p_in;
    logic [AXES-1:0][IDX_W-1:0]    idx_in;

    logic [AXES-1:0][DIFF_W-1:0]   d;
    logic [AXES-1:0][DIFF_W-1:0]   dmc;
    logic [AXES-1:0][DIFF_W-1:0]   csmd;
    logic [AXES-1:0][DIFF_W-1:0]   exc;
    logic [AXES-1:0][DIFF_W-1:0]   near;
    logic [AXES-1:0][DIFF_W-1:0]   term;
    logic [AXES-1:0]               counts;
    logic [1:0]                    n_count;
    logic                          use_exc;
    logic [DIFF_W-1:0]             cs_w;

    // Credit check: queue entries plus the item in stage A
    assign full   = ({1'b0, queue_count} + {{CNT_W{1'b0}}, valid_a_reg})
                    >= (CNT_W + 1)'(QUEUE_DEPTH);
    assign accept = push && !full;

    assign p_in   = {point_z, point_y, point_x};
    assign idx_in = {cell_z, cell_y, cell_x};

    // Stage A: low corner of the cell per axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                p_a_reg[i]  <= p_in[i];
                lo_a_reg[i] <= LO_W'(clamp_idx(idx_in[i])) * LO_W'(cell_size);
            end
        end
    end

    // Stage B: offsets, fold and per-axis terms
    assign cs_w = DIFF_W'(cell_size);

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            d[i]      = {{(DIFF_W-32){p_a_reg[i][31]}}, p_a_reg[i]}
                        - {2'b00, lo_a_reg[i]};
            dmc[i]    = d[i] - cs_w;
            csmd[i]   = cs_w - d[i];
            counts[i] = d[i][DIFF_W-1] || !dmc[i][DIFF_W-1];
            exc[i]    = d[i][DIFF_W-1] ? (~d[i] + DIFF_W'(1)) : dmc[i];
            near[i]   = counts[i] ? exc[i] : ((d[i] < csmd[i]) ? d[i] : csmd[i]);
        end
    end

    assign n_count = 2'({1'b0, counts[0]} + {1'b0, counts[1]} + {1'b0, counts[2]});
    assign use_exc = (n_count == 2'd1) || (n_count == 2'd2);

    always_comb
    begin
        wr_item.sat = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            if (use_exc)
                term[i] = counts[i] ? exc[i] : '0;
            else
                term[i] = near[i];
            wr_item.terms[i] = term[i][TERM_W-1:0];
            if (term[i][DIFF_W-1:TERM_W] != '0)
                wr_item.sat = 1'b1;
        end
        case (n_count)
            2'd1:    wr_item.kase = CASE_FACE;
            2'd2:    wr_item.kase = CASE_EDGE;
            default: wr_item.kase = CASE_CORNER;
        endcase
    end

    assign wr_valid = valid_a_reg;

endmodule

FILE: design/ptcd_queue.sv
// Short queue of classified items between the front and the back.
// Depends on ptcd_pkg.
module ptcd_queue
    import ptcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = PTCD_QUEUE_DEPTH,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
    localparam int PTR_W = $clog2(QUEUE_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    input  ptcd_item_t       wr_item,
    input  logic             rd_en,
    output logic             rd_valid,
    output ptcd_item_t       rd_item,
    output logic [CNT_W-1:0] count
);

    ptcd_item_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_rd;

    assign do_rd    = rd_en && (count_reg != '0);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign count    = count_reg;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_valid)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            if (wr_valid && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (!wr_valid && do_rd)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_valid)
            mem[wr_ptr_reg] <= wr_item;
    end

    // The front's credit check must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !do_rd |-> count_reg != CNT_W'(QUEUE_DEPTH))
        else $error("queue written while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

FILE: design/ptcd_back.sv
// Back part: squares, sum, pipelined integer square root and result register.
// Depends on ptcd_pkg.
module ptcd_back
    import ptcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_valid,
    input  ptcd_item_t        rd_item,
    output logic              rd_en,
    input  logic              pop,
    output logic              empty,
    output logic [31:0]       distance,
    output logic [1:0]        case_taken,
    output logic              saturated
);

    logic                    en;
    logic                    out_valid_reg;
    logic [31:0]             dist_reg;
    logic [1:0]              kase_out_reg;
    logic                    sat_out_reg;

    // Square stage
    logic                    sq_vld_reg;
    logic [AXES-1:0][SQ_W-1:0] sq_reg;
    logic [1:0]              sq_kase_reg;
    logic                    sq_sat_reg;
    logic [SUM_W-1:0]        sum;

    // Root stages, index 0 is the sum stage
    logic                    r_vld_reg  [TERM_W+1];
    logic [SQ_W-1:0]         r_val_reg  [TERM_W+1];
    logic [REM_W-1:0]        r_rem_reg  [TERM_W+1];
    logic [TERM_W-1:0]       r_root_reg [TERM_W+1];
    logic [1:0]              r_kase_reg [TERM_W+1];
    logic                    r_sat_reg  [TERM_W+1];

    // Whole pipeline moves unless the result register is held
    assign en    = !out_valid_reg || pop;
    assign rd_en = en;
    assign sum   = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg   <= 1'b0;
            r_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg   <= rd_valid;
            r_vld_reg[0] <= sq_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < AXES; i++)
                sq_reg[i] <= SQ_W'(rd_item.terms[i]) * SQ_W'(rd_item.terms[i]);
            sq_kase_reg   <= rd_item.kase;
            sq_sat_reg    <= rd_item.sat;
            r_val_reg[0]  <= sum[SQ_W-1:0];
            r_rem_reg[0]  <= '0;
            r_root_reg[0] <= '0;
            r_kase_reg[0] <= sq_kase_reg;
            r_sat_reg[0]  <= sq_sat_reg || (sum[SUM_W-1:SQ_W] != '0);
        end
    end

    // One root bit per stage
    for (genvar s = 1; s <= TERM_W; s++)
    begin : g_root
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             ge;

        assign rem_sh = {r_rem_reg[s-1], r_val_reg[s-1][SQ_W-1:SQ_W-2]};
        assign trial  = {2'b00, r_root_reg[s-1], 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                r_vld_reg[s] <= 1'b0;
            else if (en)
                r_vld_reg[s] <= r_vld_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_val_reg[s]  <= {r_val_reg[s-1][SQ_W-3:0], 2'b00};
                r_rem_reg[s]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                r_root_reg[s] <= {r_root_reg[s-1][TERM_W-2:0], ge};
                r_kase_reg[s] <= r_kase_reg[s-1];
                r_sat_reg[s]  <= r_sat_reg[s-1];
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= r_vld_reg[TERM_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg     <= r_sat_reg[TERM_W] ? '1 : r_root_reg[TERM_W];
            kase_out_reg <= r_kase_reg[TERM_W];
            sat_out_reg  <= r_sat_reg[TERM_W];
        end
    end

    assign empty      = !out_valid_reg;
    assign distance   = dist_reg;
    assign case_taken = kase_out_reg;
    assign saturated  = sat_out_reg;

    // A held result must not be overwritten
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(dist_reg))
        else $error("held result changed");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && sat_out_reg |-> dist_reg == '1)
        else $error("saturated result not at maximum");

    a_kase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> kase_out_reg != 2'd3)
        else $error("bad case code");

endmodule

FILE: design/point_to_cell_distance.sv
// Top level of the point to cell distance block: register port and wiring.
// Depends on ptcd_pkg, ptcd_front, ptcd_queue and ptcd_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | push / full        | point_x/y/z, cell_x/y/z
//   result   | pop / empty        | distance, case_taken, saturated
//   config   | psel/penable/pready| paddr, pwdata, prdata (cell_size at 0x0)
//
// One item per cycle is accepted and delivered while neither full nor a held
// result stalls the flow; the result reaches the ports through stage A, which
// takes the item at the accepting edge, the queue entry, one square stage, one
// sum stage, 32 square-root stages (one root bit each) and the result register.
// Reset is asynchronous and clears all valid state; cell_size resets to 1.0.
// A held result stalls the whole back pipeline; the front keeps taking items
// until the queue between the two parts has no credit left.
module point_to_cell_distance
    import ptcd_pkg::*;
#(
    parameter int QUEUE_DEPTH = PTCD_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input items
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic [7:0]         cell_x,
    input  logic [7:0]         cell_y,
    input  logic [7:0]         cell_z,
    // results
    input  logic               pop,
    output logic               empty,
    output logic [31:0]        distance,
    output logic [1:0]         case_taken,
    output logic               saturated,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CS_W-1:0]  cell_size_reg;
    logic             wr_valid;
    ptcd_item_t       wr_item;
    logic             rd_en;
    logic             rd_valid;
    ptcd_item_t       rd_item;
    logic [CNT_W-1:0] queue_count;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CELL_SIZE) ? {1'b0, cell_size_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_size_reg <= CS_W'(65536);
        else if (psel && penable && pwrite && pready && paddr == ADDR_CELL_SIZE)
            cell_size_reg <= pwdata[CS_W-1:0];
    end

    ptcd_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cell_size   (cell_size_reg),
        .push        (push),
        .full        (full),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_z      (cell_z),
        .queue_count (queue_count),
        .wr_valid    (wr_valid),
        .wr_item     (wr_item)
    );

    ptcd_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_item  (wr_item),
        .rd_en    (rd_en),
        .rd_valid (rd_valid),
        .rd_item  (rd_item),
        .count    (queue_count)
    );

    ptcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_valid   (rd_valid),
        .rd_item    (rd_item),
        .rd_en      (rd_en),
        .pop        (pop),
        .empty      (empty),
        .distance   (distance),
        .case_taken (case_taken),
        .saturated  (saturated)
    );

endmodule
